FILE: hw/rtl/ssp_pkg.sv
// Package for the soft-sphere pair force block.
// Holds widths, store depth default and sequencer codes; no dependencies.
package ssp_pkg;
    localparam int MAX_PARTICLES = 8192;
    localparam int FRAC_BITS     = 14;
    localparam int POS_W         = 24;
    localparam int RAD_W         = 14;
    localparam int CNT_W         = 14;
    localparam int SLOT_W        = 13;
    localparam int FORCE_W       = 32;
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
endpackage

FILE: hw/rtl/ssp_divider.sv
// Shared iterative unit: restoring square root and restoring divide, one bit a cycle.
// Depends on ssp_pkg for nothing but kept in the same project style.
module ssp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [49:0] i_a,
    input  logic [29:0] i_b,
    output logic        o_done,
    output logic [29:0] o_res
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_sq;
    logic [49:0] r_a;
    logic [31:0] r_rem;
    logic [29:0] r_b;
    logic [29:0] r_q;
    logic [31:0] n_rem;
    logic [31:0] trial;
    logic [31:0] cand;

    always_comb begin
        if (r_sq) begin
            n_rem = {r_rem[29:0], r_a[49:48]};
            cand  = {r_q, 2'b01};
        end else begin
            n_rem = {r_rem[30:0], r_a[49]};
            cand  = {2'b00, r_b};
        end
        trial = n_rem - cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sq   <= i_sqrt;
                r_a    <= i_a;
                r_b    <= i_b;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= i_sqrt ? 6'd25 : 6'd50;
            end else if (r_busy) begin
                r_a <= r_sq ? {r_a[47:0], 2'b00} : {r_a[48:0], 1'b0};
                if (!trial[31]) begin
                    r_rem <= trial;
                    r_q   <= {r_q[28:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[28:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_res = r_q;
endmodule

FILE: hw/rtl/soft_sphere_pair_force.sv
// Top level of the soft-sphere pair force block: particle store and query sequencer.
// Depends on ssp_pkg and ssp_divider.
//
// channel  | handshake                 | payload
// command  | i_start / o_busy          | i_mode i_slot i_pos_x i_pos_y i_radius
// config   | i_cfg_valid / o_cfg_ready | i_cfg_data (particle_count)
// result   | o_valid strobe            | o_force_x o_force_y o_saturated
//
// A load is written at its accepting edge and never raises o_busy. A query holds o_busy
// while it walks the slots below the active count (capped at MAX_P), reading each through
// the single store read port, and runs the one-bit-a-cycle root and divide unit for each
// pair in contact; o_valid pulses in the first cycle with o_busy low.
// Synchronous active-low reset clears control; the store is not cleared.
// The result strobe lasts one cycle and cannot be stalled.
module soft_sphere_pair_force #(
    parameter int MAX_P = ssp_pkg::MAX_PARTICLES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_mode,
    input  logic [ssp_pkg::SLOT_W-1:0]  i_slot,
    input  logic [ssp_pkg::POS_W-1:0]   i_pos_x,
    input  logic [ssp_pkg::POS_W-1:0]   i_pos_y,
    input  logic [ssp_pkg::RAD_W-1:0]   i_radius,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ssp_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    output logic signed [ssp_pkg::FORCE_W-1:0] o_force_x,
    output logic signed [ssp_pkg::FORCE_W-1:0] o_force_y,
    output logic                        o_saturated
);
    import ssp_pkg::*;
    localparam int AW = (MAX_P > 1) ? $clog2(MAX_P) : 1;
    localparam int KW = AW + 1;
    localparam int DW = POS_W + POS_W + RAD_W;
    localparam int QW = 30;
    localparam int D2W = 50;

    localparam logic [3:0] S_IDLE = 4'd0, S_RDI = 4'd1, S_LATI = 4'd2, S_RDK = 4'd3,
                           S_WAIT = 4'd4, S_DX = 4'd5, S_SQ1 = 4'd6, S_SQ2 = 4'd7,
                           S_CMP = 4'd8, S_SQRT = 4'd9, S_DIV = 4'd10, S_MX = 4'd11,
                           S_MY = 4'd12, S_ACC = 4'd13, S_OUT = 4'd14, S_NEXT = 4'd15;

    logic [DW-1:0] mem [MAX_P];
    logic [DW-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic [3:0]  r_st;
    logic [CNT_W-1:0] r_count;
    logic [SLOT_W-1:0] r_slot;
    logic [KW-1:0] r_k, lim;
    logic [POS_W-1:0] r_xi, r_yi;
    logic [RAD_W-1:0] r_ai;
    logic signed [POS_W:0] r_dx, r_dy;
    logic [RAD_W:0] r_s;
    logic [D2W-1:0] r_d2;
    logic [QW-1:0] r_q;
    logic [QW+POS_W-1:0] r_prod;
    logic signed [FORCE_W-1:0] r_fx, r_fy;
    logic r_sat;
    logic du_start, du_sqrt, du_done;
    logic [D2W-1:0] du_a;
    logic [QW-1:0] du_b;
    logic [QW-1:0] du_res;
    logic [POS_W-1:0] kx, ky, dx_mag, dy_mag;
    logic [RAD_W-1:0] ka;
    logic [QW-1:0] mul_a;
    logic [POS_W-1:0] mul_b;
    logic [QW+POS_W-1:0] mul_p;
    logic [FORCE_W-1:0] term_mag;
    logic neg;
    logic signed [FORCE_W+1:0] term, sum;
    logic signed [FORCE_W-1:0] acc, clamped;
    logic csat;

    assign kx = r_rd[DW-1 -: POS_W];
    assign ky = r_rd[RAD_W +: POS_W];
    assign ka = r_rd[RAD_W-1:0];
    assign lim = (int'(r_count) > MAX_P) ? KW'(MAX_P) : KW'(r_count);
    assign rd_addr = (r_st == S_RDI) ? AW'(r_slot) : r_k[AW-1:0];
    assign o_busy = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);

    ssp_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(du_start), .i_sqrt(du_sqrt),
        .i_a(du_a), .i_b(du_b), .o_done(du_done), .o_res(du_res)
    );

    always_comb begin
        du_start = (r_st == S_CMP) || (r_st == S_SQRT && du_done && du_res != '0);
        du_sqrt  = (r_st == S_CMP);
        du_a     = (r_st == S_CMP) ? r_d2 : D2W'({r_s, 14'd0});
        du_b     = du_res;
        dx_mag   = r_dx[POS_W] ? POS_W'(-r_dx) : r_dx[POS_W-1:0];
        dy_mag   = r_dy[POS_W] ? POS_W'(-r_dy) : r_dy[POS_W-1:0];
        case (r_st)
            S_DX: begin
                mul_a = QW'(dx_mag);
                mul_b = dx_mag;
            end
            S_SQ1: begin
                mul_a = QW'(dy_mag);
                mul_b = dy_mag;
            end
            S_SQ2: begin
                mul_a = QW'(r_s);
                mul_b = POS_W'(r_s);
            end
            S_MX: begin
                mul_a = r_q;
                mul_b = dx_mag;
            end
            default: begin
                mul_a = r_q;
                mul_b = dy_mag;
            end
        endcase
        mul_p    = mul_a * mul_b;
        term_mag = r_prod[FRAC_BITS +: FORCE_W];
        neg      = (r_st == S_MY) ? r_dx[POS_W] : r_dy[POS_W];
        acc      = (r_st == S_MY) ? r_fx : r_fy;
        term     = neg ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
        sum      = (FORCE_W+2)'(acc) + term;
        csat     = 1'b0;
        clamped  = sum[FORCE_W-1:0];
        if (!(sum[FORCE_W+1:FORCE_W-1] inside {3'b000, 3'b111})) begin
            csat    = 1'b1;
            clamped = sum[FORCE_W+1] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                     : {1'b0, {(FORCE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy && i_mode == MODE_LOAD && int'(i_slot) < MAX_P)
            mem[AW'(i_slot)] <= {i_pos_x, i_pos_y, i_radius};
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready)
                r_count <= i_cfg_data;
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_slot <= i_slot;
                    r_fx <= '0; r_fy <= '0; r_sat <= 1'b0; r_k <= '0;
                    if (i_mode == MODE_QUERY)
                        r_st <= (int'(i_slot) < MAX_P) ? S_RDI : S_OUT;
                end
                S_RDI: r_st <= S_LATI;
                S_LATI: begin
                    r_xi <= kx; r_yi <= ky; r_ai <= ka; r_st <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_k >= lim)
                        r_st <= S_OUT;
                    else if (r_k == KW'(r_slot))
                        r_k <= r_k + KW'(1);
                    else
                        r_st <= S_RDK;
                end
                S_RDK: r_st <= S_WAIT;
                S_WAIT: begin
                    r_dx <= $signed({1'b0, r_xi}) - $signed({1'b0, kx});
                    r_dy <= $signed({1'b0, r_yi}) - $signed({1'b0, ky});
                    r_s  <= {1'b0, r_ai} + {1'b0, ka};
                    r_st <= S_DX;
                end
                S_DX: begin
                    r_d2 <= D2W'(mul_p);
                    r_st <= S_SQ1;
                end
                S_SQ1: begin
                    r_d2 <= r_d2 + D2W'(mul_p);
                    r_st <= S_SQ2;
                end
                S_SQ2: begin
                    if (r_d2 != '0 && r_d2 < D2W'(mul_p)) begin
                        r_st <= S_CMP;
                    end else begin
                        r_k  <= r_k + KW'(1);
                        r_st <= S_NEXT;
                    end
                end
                S_CMP: r_st <= S_SQRT;
                S_SQRT: if (du_done) begin
                    if (du_res != '0) begin
                        r_st <= S_DIV;
                    end else begin
                        r_k  <= r_k + KW'(1);
                        r_st <= S_NEXT;
                    end
                end
                S_DIV: if (du_done) begin
                    r_q <= du_res - 30'd16384;
                    r_st <= S_MX;
                end
                S_MX: begin
                    r_prod <= mul_p;
                    r_st <= S_MY;
                end
                S_MY: begin
                    r_fx   <= clamped;
                    r_sat  <= r_sat | csat;
                    r_prod <= mul_p;
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    r_fy  <= clamped;
                    r_sat <= r_sat | csat;
                    r_k   <= r_k + KW'(1);
                    r_st  <= S_NEXT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_force_x = r_fx;
    assign o_force_y = r_fy;
    assign o_saturated = r_sat;
endmodule

FILE: tb/sv/tb_soft_sphere_pair_force.sv
`timescale 1ns / 100ps
// Testbench for soft_sphere_pair_force: loads particles, queries pair forces and checks
// each result against a fixed-point force predictor kept in the bench. Depends on ssp_pkg.
module tb_soft_sphere_pair_force;
    import ssp_pkg::*;

    localparam int IDLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic                mode;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [RAD_W-1:0]    radius;
    } t_particle_cmd;

    typedef struct {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      saturated;
    } t_force_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_mode = MODE_LOAD;
    logic [SLOT_W-1:0]  i_slot = '0;
    logic [POS_W-1:0]   i_pos_x = '0;
    logic [POS_W-1:0]   i_pos_y = '0;
    logic [RAD_W-1:0]   i_radius = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic signed [FORCE_W-1:0] o_force_x;
    logic signed [FORCE_W-1:0] o_force_y;
    logic               o_saturated;

    soft_sphere_pair_force DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_mode(i_mode), .i_slot(i_slot), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_radius(i_radius), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_force_x(o_force_x),
        .o_force_y(o_force_y), .o_saturated(o_saturated)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_particle_cmd  pending_cmds[$];
    t_force_result  expected_forces[$];
    logic [POS_W-1:0] particle_x[MAX_PARTICLES];
    logic [POS_W-1:0] particle_y[MAX_PARTICLES];
    logic [RAD_W-1:0] particle_r[MAX_PARTICLES];
    bit             slot_loaded[MAX_PARTICLES];
    logic [CNT_W-1:0] active_count = '0;
    int             mismatches = 0;
    int             loads_done = 0;
    int             queries_done = 0;
    int             idle_cycles = 0;
    bit             no_idle = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint repulse_term(longint unsigned q, longint d);
        longint unsigned mag;
        longint t;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        t = longint'((q * mag) >> FRAC_BITS);
        return (d < 0) ? -t : t;
    endfunction

    function automatic longint clamp_add(longint acc, longint t, ref bit flag);
        longint s;
        s = acc + t;
        if (s > 64'sd2147483647) begin s = 64'sd2147483647; flag = 1'b1; end
        if (s < -64'sd2147483648) begin s = -64'sd2147483648; flag = 1'b1; end
        return s;
    endfunction

    function automatic t_force_result predict_force(int unsigned qs);
        t_force_result res;
        longint fx, fy, dx, dy;
        longint unsigned d2, s, r, q;
        int unsigned n;
        bit sat;
        fx = 0; fy = 0; sat = 1'b0;
        n = (int'(active_count) > MAX_PARTICLES) ? MAX_PARTICLES : int'(active_count);
        for (int unsigned k = 0; k < n; k++) begin
            if (k == qs) continue;
            dx = longint'(particle_x[SLOT_W'(qs)]) - longint'(particle_x[SLOT_W'(k)]);
            dy = longint'(particle_y[SLOT_W'(qs)]) - longint'(particle_y[SLOT_W'(k)]);
            if (dx == 0 && dy == 0) continue;
            d2 = longint'(dx * dx) + longint'(dy * dy);
            s = longint'(particle_r[SLOT_W'(qs)]) + longint'(particle_r[SLOT_W'(k)]);
            if (d2 >= s * s) continue;
            r = int_sqrt(d2);
            if (r == 0) continue;
            q = ((s << FRAC_BITS) / r) - (64'd1 << FRAC_BITS);
            fx = clamp_add(fx, repulse_term(q, dx), sat);
            fy = clamp_add(fy, repulse_term(q, dy), sat);
        end
        res.force_x = fx[FORCE_W-1:0];
        res.force_y = fy[FORCE_W-1:0];
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // driver: issue transactions and update the predictor on acceptance
    int            gap_left = 0;
    t_particle_cmd cur_cmd;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) active_count = i_cfg_data;
            if (i_start && !o_busy) begin
                if (cur_cmd.mode == MODE_LOAD) begin
                    particle_x[cur_cmd.slot] = cur_cmd.pos_x;
                    particle_y[cur_cmd.slot] = cur_cmd.pos_y;
                    particle_r[cur_cmd.slot] = cur_cmd.radius;
                    loads_done++;
                end else begin
                    expected_forces.insert(expected_forces.size(),
                                           predict_force(32'(cur_cmd.slot)));
                    queries_done++;
                end
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                i_mode <= cur_cmd.mode;
                i_slot <= cur_cmd.slot;
                i_pos_x <= cur_cmd.pos_x;
                i_pos_y <= cur_cmd.pos_y;
                i_radius <= cur_cmd.radius;
                i_start <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare results, watch for a hang
    t_force_result want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout waiting for a transaction");
                $display("FAIL soft_sphere_pair_force");
                $finish;
            end
            if (o_valid) begin
                if (expected_forces.size() == 0) begin
                    report_mismatch("unexpected result force_x", o_force_x, 0);
                end else begin
                    want = expected_forces.pop_front();
                    if (o_force_x !== want.force_x)
                        report_mismatch("force_x", o_force_x, want.force_x);
                    if (o_force_y !== want.force_y)
                        report_mismatch("force_y", o_force_y, want.force_y);
                    if (o_saturated !== want.saturated)
                        report_mismatch("saturated", o_saturated, want.saturated);
                end
            end
        end
    end

    task automatic add_load(int unsigned slot, int unsigned px, int unsigned py,
                            int unsigned rad);
        t_particle_cmd c;
        c.mode = MODE_LOAD; c.slot = SLOT_W'(slot); c.pos_x = POS_W'(px);
        c.pos_y = POS_W'(py); c.radius = RAD_W'(rad);
        pending_cmds.insert(pending_cmds.size(), c);
        slot_loaded[c.slot] = 1'b1;
    endtask

    task automatic add_query(int unsigned slot);
        t_particle_cmd c;
        c.mode = MODE_QUERY; c.slot = SLOT_W'(slot);
        c.pos_x = POS_W'($urandom()); c.pos_y = POS_W'($urandom());
        c.radius = RAD_W'($urandom());
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_forces.size() > 0 || i_start || o_busy)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CNT_W'(value);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // set the count, fill slots below it with a cluster so that many pairs touch, then mix loads and queries
    task automatic cluster_phase(int unsigned n, int unsigned items);
        int unsigned bx, by, s, r;
        bx = $urandom_range(0, 24'hFFFFFF - 24'h10000);
        by = $urandom_range(0, 24'hFFFFFF - 24'h10000);
        write_count(n);
        for (int unsigned k = 0; k < n; k++)
            add_load(k, bx + $urandom_range(0, 24'h8000), by + $urandom_range(0, 24'h8000),
                     $urandom_range(2048, 16383));
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_load($urandom_range(0, n - 1), bx + $urandom_range(0, 24'h8000),
                         by + $urandom_range(0, 24'h8000), $urandom_range(0, 16383));
            end else if (r < 50) begin
                add_load($urandom_range(0, MAX_PARTICLES - 1), $urandom_range(0, 24'hFFFFFF),
                         $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 16383));
            end else begin
                do s = $urandom_range(0, MAX_PARTICLES - 1); while (!slot_loaded[SLOT_W'(s)]);
                if ($urandom_range(0, 3) != 0) s = $urandom_range(0, n - 1);
                add_query(s);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_count(0);
        add_load(0, 0, 0, 0);
        add_query(0);
        wait_idle();

        write_count(6);
        add_load(0, 24'h10000, 24'h10000, 8192);
        add_load(1, 24'h10000, 24'h10000, 8192);
        add_load(2, 24'h10000 + 4000, 24'h10000 - 3000, 16383);
        add_load(3, 24'hFFFFFF, 24'hFFFFFF, 16383);
        add_load(4, 24'hFFFFFF - 100, 24'hFFFFFF, 0);
        add_load(5, 0, 0, 0);
        add_load(8191, 24'h10000 + 1, 24'h10000, 16383);
        for (int k = 0; k < 6; k++) add_query(k);
        add_query(8191);
        wait_idle();

        no_idle = 1'b1;
        cluster_phase(12, 20);
        no_idle = 1'b0;
        cluster_phase(20, 20);
        cluster_phase(2, 10);

        write_count(1);
        add_query(0);
        add_query(5);
        wait_idle();

        $display("covered %0d loads and %0d queries", loads_done, queries_done);
        $display("counts 0, 1, 2, 6, 12 and 20, coincident and close pairs; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASS soft_sphere_pair_force");
        else
            $display("FAIL soft_sphere_pair_force");
        $finish;
    end
endmodule
